// ----- src/sdsce_pkg.sv -----
// Shared types, field offsets and frame helpers for the SD SPI command engine.
package sdsce_pkg;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_DESEL   = 4'd1,
        PH_SEL     = 4'd2,
        PH_READY   = 4'd3,
        PH_FRAME   = 4'd4,
        PH_DISCARD = 4'd5,
        PH_RESP    = 4'd6,
        PH_TDESEL  = 4'd7
    } phase_t;

    // Configuration register indexes
    localparam logic REG_READY_TIMEOUT = 1'b0;
    localparam logic REG_POLL_LIMIT    = 1'b1;

    localparam logic [15:0] READY_TIMEOUT_RST = 16'd500;
    localparam logic [7:0]  POLL_LIMIT_RST    = 8'd10;

    localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
    localparam logic [5:0] CMD_IF_COND   = 6'd8;
    localparam logic [5:0] CMD_STOP      = 6'd12;
    localparam logic [5:0] CMD_APP_CMD   = 6'd55;

    localparam logic [7:0] BYTE_IDLE     = 8'hFF;
    localparam logic [7:0] START_BITS    = 8'h40;
    localparam logic [7:0] CRC_CMD0      = 8'h95;
    localparam logic [7:0] CRC_CMD8      = 8'h87;
    localparam logic [7:0] CRC_OTHER     = 8'h01;
    localparam logic [7:0] FRAME_LEN     = 8'd6;

    // Input tdata layout
    localparam int IN_TDATA_W = 48;
    // Result tdata layout
    localparam int OUT_TDATA_W  = 24;
    localparam int OB_TX_VALID  = 0;
    localparam int OB_TX_BYTE   = 1;
    localparam int OB_CS        = 9;
    localparam int OB_DONE      = 10;
    localparam int OB_RESPONSE  = 11;
    localparam int OB_TIMED_OUT = 19;

    // Byte k of the six-byte command frame
    function automatic logic [7:0] frame_byte(input logic [7:0] k, input logic [5:0] cmd,
                                              input logic [31:0] arg);
        logic [7:0] b;
        case (k)
            8'd0: b = START_BITS | {2'b00, cmd};
            8'd1: b = arg[31:24];
            8'd2: b = arg[23:16];
            8'd3: b = arg[15:8];
            8'd4: b = arg[7:0];
            default: begin
                if (cmd == CMD_GO_IDLE)      b = CRC_CMD0;
                else if (cmd == CMD_IF_COND) b = CRC_CMD8;
                else                         b = CRC_OTHER;
            end
        endcase
        return b;
    endfunction

endpackage

// ----- src/sd_spi_command_engine.sv -----
// SD card SPI-mode command engine: sequences one command as byte exchanges.
//
// Usage: the host sends transactions on the s_axis channel. tuser carries the
// operation (start command, card byte received, millisecond tick); tdata
// carries the command index, application flag, argument and the card byte.
// Each start or card byte may produce one result transaction on m_axis: either
// a byte to clock out (tx_valid) together with the select line state, or the
// finish of the command with the R1 response and a timeout flag.
// The host clocks out each requested byte and returns the card's answer as
// the next card-byte transaction; ticks drive the ready timeout.
// A result appears in the output register in the cycle after the transaction
// is accepted. Throughput: one transaction per cycle unless the output stalls;
// all work is a single combinational pass from the accepted transaction and
// the sequencer state into the state and result registers.
// Stall: s_axis_tready drops only while a result sits in the output register
// and the receiver holds m_axis_tready low; the result is held unchanged.
// Reset (aresetn low, synchronous): sequencer idle, select line inactive,
// result register empty, registers back to 500 ticks and 10 polls.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, no handshake.
module sd_spi_command_engine #(
    parameter int TIMER_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [5:0] command_index, [6] app_command, [38:7] argument, [46:39] rx_byte
    input  logic [47:0] s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] tx_valid, [8:1] tx_byte, [9] chip_select_active, [10] done_res,
    // [18:11] response, [19] timed_out
    output logic [23:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    // Configuration registers
    logic [15:0] ready_timeout_reg;
    logic [7:0]  poll_limit_reg;

    // Sequencer state
    sdsce_pkg::phase_t      phase_reg, phase_next;
    logic [7:0]             byte_count_reg, byte_count_next;
    logic [5:0]             held_index_reg, held_index_next;
    logic [31:0]            held_argument_reg, held_argument_next;
    logic                   prefix_reg, prefix_next;
    logic [TIMER_BITS-1:0]  ticks_left_reg, ticks_left_next;
    logic                   cs_reg, cs_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg, out_data_next;

    logic        accept;
    logic [1:0]  op;
    logic [5:0]  in_index;
    logic        in_app;
    logic [31:0] in_arg;
    logic [7:0]  in_rx;
    logic [47:0] timeout_wide;

    assign op       = s_axis_tuser;
    assign in_index = s_axis_tdata[5:0];
    assign in_app   = s_axis_tdata[6];
    assign in_arg   = s_axis_tdata[38:7];
    assign in_rx    = s_axis_tdata[46:39];

    // Timer load, zero-extended then cut to the timer width
    assign timeout_wide = {32'd0, ready_timeout_reg};

    // Output register frees up when empty or being taken this cycle
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_timeout_reg <= sdsce_pkg::READY_TIMEOUT_RST;
            poll_limit_reg    <= sdsce_pkg::POLL_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                sdsce_pkg::REG_READY_TIMEOUT: ready_timeout_reg <= cfg_wdata;
                sdsce_pkg::REG_POLL_LIMIT:    poll_limit_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= sdsce_pkg::PH_IDLE;
            byte_count_reg    <= '0;
            held_index_reg    <= '0;
            held_argument_reg <= '0;
            prefix_reg        <= 1'b0;
            ticks_left_reg    <= '0;
            cs_reg            <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            held_index_reg    <= held_index_next;
            held_argument_reg <= held_argument_next;
            prefix_reg        <= prefix_next;
            ticks_left_reg    <= ticks_left_next;
            cs_reg            <= cs_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    always_comb begin
        logic       emit;
        logic       r_tx_valid;
        logic [7:0] r_tx_byte;
        logic       r_done;
        logic [7:0] r_resp;
        logic       r_to;
        logic       do_begin;
        logic       do_poll;
        logic [5:0] cur_cmd;
        logic [31:0] cur_arg;
        logic [7:0] cnt_inc;

        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        held_index_next    = held_index_reg;
        held_argument_next = held_argument_reg;
        prefix_next        = prefix_reg;
        ticks_left_next    = ticks_left_reg;
        cs_next            = cs_reg;
        emit       = 1'b0;
        r_tx_valid = 1'b0;
        r_tx_byte  = '0;
        r_done     = 1'b0;
        r_resp     = '0;
        r_to       = 1'b0;
        do_begin   = 1'b0;
        do_poll    = 1'b0;
        cnt_inc    = byte_count_reg + 8'd1;

        if (accept) begin
            case (op)
                sdsce_pkg::OP_TICK: begin
                    if (ticks_left_reg != '0)
                        ticks_left_next = ticks_left_reg - TIMER_BITS'(1);
                end
                sdsce_pkg::OP_START: begin
                    if (phase_reg == sdsce_pkg::PH_IDLE) begin
                        held_index_next    = in_index;
                        prefix_next        = in_app;
                        held_argument_next = in_arg;
                        do_begin           = 1'b1;
                    end
                end
                sdsce_pkg::OP_RX: begin
                    case (phase_reg)
                        sdsce_pkg::PH_DESEL: begin
                            cs_next    = 1'b1;
                            phase_next = sdsce_pkg::PH_SEL;
                            emit = 1'b1; r_tx_valid = 1'b1; r_tx_byte = sdsce_pkg::BYTE_IDLE;
                        end
                        sdsce_pkg::PH_SEL: begin
                            ticks_left_next = timeout_wide[TIMER_BITS-1:0];
                            phase_next      = sdsce_pkg::PH_READY;
                            emit = 1'b1; r_tx_valid = 1'b1; r_tx_byte = sdsce_pkg::BYTE_IDLE;
                        end
                        sdsce_pkg::PH_READY: begin
                            emit = 1'b1; r_tx_valid = 1'b1;
                            if (in_rx == sdsce_pkg::BYTE_IDLE) begin
                                phase_next      = sdsce_pkg::PH_FRAME;
                                byte_count_next = '0;
                                cur_cmd   = prefix_reg ? sdsce_pkg::CMD_APP_CMD : held_index_reg;
                                cur_arg   = prefix_reg ? 32'd0 : held_argument_reg;
                                r_tx_byte = sdsce_pkg::frame_byte(8'd0, cur_cmd, cur_arg);
                            end else begin
                                r_tx_byte = sdsce_pkg::BYTE_IDLE;
                                if (ticks_left_reg == '0) begin
                                    cs_next    = 1'b0;
                                    phase_next = sdsce_pkg::PH_TDESEL;
                                end
                            end
                        end
                        sdsce_pkg::PH_FRAME: begin
                            byte_count_next = cnt_inc;
                            cur_cmd = prefix_reg ? sdsce_pkg::CMD_APP_CMD : held_index_reg;
                            cur_arg = prefix_reg ? 32'd0 : held_argument_reg;
                            if (cnt_inc < sdsce_pkg::FRAME_LEN) begin
                                emit = 1'b1; r_tx_valid = 1'b1;
                                r_tx_byte = sdsce_pkg::frame_byte(cnt_inc, cur_cmd, cur_arg);
                            end else if (cur_cmd == sdsce_pkg::CMD_STOP) begin
                                phase_next = sdsce_pkg::PH_DISCARD;
                                emit = 1'b1; r_tx_valid = 1'b1;
                                r_tx_byte = sdsce_pkg::BYTE_IDLE;
                            end else begin
                                do_poll = 1'b1;
                            end
                        end
                        sdsce_pkg::PH_DISCARD: do_poll = 1'b1;
                        sdsce_pkg::PH_RESP: begin
                            if (in_rx[7] && byte_count_reg > 8'd1) begin
                                byte_count_next = byte_count_reg - 8'd1;
                                emit = 1'b1; r_tx_valid = 1'b1;
                                r_tx_byte = sdsce_pkg::BYTE_IDLE;
                            end else if (prefix_reg && in_rx <= 8'd1) begin
                                // CMD55 accepted: go straight on to the real command
                                prefix_next = 1'b0;
                                do_begin    = 1'b1;
                            end else begin
                                phase_next  = sdsce_pkg::PH_IDLE;
                                prefix_next = 1'b0;
                                emit = 1'b1; r_done = 1'b1; r_resp = in_rx;
                            end
                        end
                        sdsce_pkg::PH_TDESEL: begin
                            phase_next  = sdsce_pkg::PH_IDLE;
                            prefix_next = 1'b0;
                            emit = 1'b1; r_done = 1'b1;
                            r_resp = sdsce_pkg::BYTE_IDLE; r_to = 1'b1;
                        end
                        default: phase_next = sdsce_pkg::PH_IDLE;
                    endcase
                end
                default: ;
            endcase
        end

        cur_cmd = prefix_next ? sdsce_pkg::CMD_APP_CMD : held_index_next;
        cur_arg = prefix_next ? 32'd0 : held_argument_next;

        if (do_begin) begin
            emit = 1'b1; r_tx_valid = 1'b1;
            if (cur_cmd != sdsce_pkg::CMD_STOP) begin
                cs_next    = 1'b0;
                phase_next = sdsce_pkg::PH_DESEL;
                r_tx_byte  = sdsce_pkg::BYTE_IDLE;
            end else begin
                // CMD12 goes out with the select line left as it is
                phase_next      = sdsce_pkg::PH_FRAME;
                byte_count_next = '0;
                r_tx_byte       = sdsce_pkg::frame_byte(8'd0, cur_cmd, cur_arg);
            end
        end

        if (do_poll) begin
            byte_count_next = (poll_limit_reg != 8'd0) ? poll_limit_reg : 8'd1;
            phase_next      = sdsce_pkg::PH_RESP;
            emit = 1'b1; r_tx_valid = 1'b1; r_tx_byte = sdsce_pkg::BYTE_IDLE;
        end

        // Output register: load on a new result, clear once taken
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = {4'd0, r_to, r_resp, r_done, cs_next, r_tx_byte, r_tx_valid};
        end else begin
            out_valid_next = out_valid_reg && !m_axis_tready;
            out_data_next  = out_data_reg;
        end
    end

endmodule

// ----- src/sdsce_checker.sv -----
// Port-level checker for the SD SPI command engine, bound to the top level.
module sdsce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_done;
    logic [7:0] o_resp;
    logic       o_to;

    assign o_tx_valid = m_axis_tdata[sdsce_pkg::OB_TX_VALID];
    assign o_tx_byte  = m_axis_tdata[sdsce_pkg::OB_TX_BYTE +: 8];
    assign o_done     = m_axis_tdata[sdsce_pkg::OB_DONE];
    assign o_resp     = m_axis_tdata[sdsce_pkg::OB_RESPONSE +: 8];
    assign o_to       = m_axis_tdata[sdsce_pkg::OB_TIMED_OUT];

    // Stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // A result is either a byte to clock or a finish, never both or neither
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (o_tx_valid != o_done))
        else $error("result is not exactly one of byte or finish");

    // Timeout finish always reports 0xFF
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && o_to |-> o_done && o_resp == sdsce_pkg::BYTE_IDLE)
        else $error("timeout without 0xFF finish");

    // Unused fields stay zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (o_tx_valid || o_tx_byte == 8'd0) &&
                          (o_done || (o_resp == 8'd0 && !o_to)))
        else $error("idle fields not zero");

endmodule

bind sd_spi_command_engine sdsce_checker u_sdsce_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
